>>> hdl/stm_pkg.sv
// ----------------------------------------------------------------------------
// stm_pkg
// Shared types and constants for the sparse triplet multiplier.
// ----------------------------------------------------------------------------
package stm_pkg;

  localparam int DEF_MAX_TERMS = 16;
  localparam int DEF_MAX_DIM   = 16;
  localparam int OUT_CAP       = 16;
  localparam int OUT_IDX_W     = $clog2(OUT_CAP);
  localparam int VAL_W         = 36;

  typedef enum logic [1:0] {
    KIND_LOAD_A  = 2'd0,
    KIND_LOAD_B  = 2'd1,
    KIND_COMPUTE = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [15:0] val;
  } term_t;

  typedef struct packed {
    logic [3:0]             row;
    logic [3:0]             col;
    logic signed [VAL_W-1:0] val;
  } elem_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ELEM,
    ST_A_RD,
    ST_A_CHK,
    ST_A_NEXT,
    ST_B_RD,
    ST_B_CHK,
    ST_B_ACC,
    ST_ELEM_DONE,
    ST_EMIT_RD,
    ST_EMIT_LOAD,
    ST_EMIT_WAIT
  } state_t;

endpackage

>>> hdl/sparse_triplet_multiply_top.sv
// ----------------------------------------------------------------------------
// sparse_triplet_multiply_top
// Product of two sparse matrices loaded as coordinate terms.
// ----------------------------------------------------------------------------
// Input beats on s_*: tuser carries the kind. A load beat stores one term of
// A or of B; s_tready stays high. Terms beyond MAX_TERMS are dropped and
// flag overflow on the next product. A compute beat starts a scan of every
// result element in row-major order. Each element walks all A terms (read,
// check, next) and, for an A term on that row, all B terms (read, check,
// accumulate), one term at a time through the single read port of each term
// memory. Nonzero sums go to a result buffer; once the scan is over the
// results leave on m_* one beat at a time, each read from the buffer before
// it is offered, the last with tlast set. An empty product gives one beat
// with has_term clear.
// While a product runs or its results are delivered, s_tready is low.
// A stalled receiver holds the output register; nothing is lost.
// Reset empties both term stores and clears the overflow flag; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module sparse_triplet_multiply_top #(
  parameter int MAX_TERMS = stm_pkg::DEF_MAX_TERMS,
  parameter int MAX_DIM   = stm_pkg::DEF_MAX_DIM
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // row[3:0], col[7:4], value[23:8], result_rows[28:24], result_cols[33:29]
  input  logic [39:0] s_tdata,
  // kind[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_row[3:0], out_col[7:4], out_value[43:8]
  output logic [47:0] m_tdata,
  // has_term[0], overflow[1]
  output logic [1:0]  m_tuser,
  output logic        m_tlast
);
  import stm_pkg::*;

  localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W = $clog2(MAX_TERMS + 1);
  localparam int ACC_W = 33 + 2 * $clog2(MAX_TERMS);

  state_t state, state_next;

  logic [CNT_W-1:0] a_count, b_count;
  logic [CNT_W-1:0] p, q;
  logic             load_ovf, dropped;
  logic [4:0]       rows_lim, cols_lim, i, j;
  logic [4:0]       n, k;
  logic [3:0]       a_col_l;
  logic signed [15:0]      a_val_l;
  logic signed [31:0]      prod;
  logic signed [ACC_W-1:0] acc;

  term_t in_term, a_rd, b_rd;
  elem_t buf_wr, buf_rd;
  logic  a_wr, b_wr, buf_we;

  logic [4:0] in_rows, in_cols, in_rows_lim, in_cols_lim;
  logic       a_match, b_match, p_last, q_last, col_last, elem_last, emit_last;
  logic [VAL_W-1:0] sat_val;

  assign in_term.row = s_tdata[3:0];
  assign in_term.col = s_tdata[7:4];
  assign in_term.val = s_tdata[23:8];
  assign in_rows     = s_tdata[28:24];
  assign in_cols     = s_tdata[33:29];
  assign in_rows_lim = (32'(in_rows) > MAX_DIM) ? 5'(MAX_DIM) : in_rows;
  assign in_cols_lim = (32'(in_cols) > MAX_DIM) ? 5'(MAX_DIM) : in_cols;

  assign a_match   = (a_rd.row == i[3:0]) && !i[4] && (b_count != '0);
  assign b_match   = (b_rd.col == j[3:0]) && !j[4] && (b_rd.row == a_col_l);
  assign p_last    = (CNT_W'(p + 1'b1) == a_count);
  assign q_last    = (CNT_W'(q + 1'b1) == b_count);
  assign col_last  = (5'(j + 1'b1) == cols_lim);
  assign elem_last = col_last && (5'(i + 1'b1) == rows_lim);
  assign emit_last = (n == '0) || (5'(k + 1'b1) == n);

  // Clamp the exact sum into the 36-bit signed range.
  assign sat_val = (&acc[ACC_W-1:VAL_W-1] || ~|acc[ACC_W-1:VAL_W-1]) ? acc[VAL_W-1:0]
                 : {acc[ACC_W-1], {(VAL_W-1){~acc[ACC_W-1]}}};

  assign buf_wr.row = i[3:0];
  assign buf_wr.col = j[3:0];
  assign buf_wr.val = sat_val;

  stm_term_store #(.DEPTH(MAX_TERMS), .IDX_W(IDX_W)) u_a_store (
    .clk     (clk),
    .wr_en   (a_wr),
    .wr_addr (a_count[IDX_W-1:0]),
    .wr_data (in_term),
    .rd_addr (p[IDX_W-1:0]),
    .rd_data (a_rd)
  );

  stm_term_store #(.DEPTH(MAX_TERMS), .IDX_W(IDX_W)) u_b_store (
    .clk     (clk),
    .wr_en   (b_wr),
    .wr_addr (b_count[IDX_W-1:0]),
    .wr_data (in_term),
    .rd_addr (q[IDX_W-1:0]),
    .rd_data (b_rd)
  );

  stm_result_buf u_result_buf (
    .clk     (clk),
    .wr_en   (buf_we),
    .wr_addr (n[OUT_IDX_W-1:0]),
    .wr_data (buf_wr),
    .rd_addr (k[OUT_IDX_W-1:0]),
    .rd_data (buf_rd)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid && kind_t'(s_tuser) == KIND_COMPUTE) begin
          if (in_rows_lim == '0 || in_cols_lim == '0) begin
            state_next = ST_EMIT_RD;
          end else begin
            state_next = ST_ELEM;
          end
        end
      end
      ST_ELEM:      state_next = (a_count == '0) ? ST_ELEM_DONE : ST_A_RD;
      ST_A_RD:      state_next = ST_A_CHK;
      ST_A_CHK:     state_next = a_match ? ST_B_RD : ST_A_NEXT;
      ST_A_NEXT:    state_next = p_last ? ST_ELEM_DONE : ST_A_RD;
      ST_B_RD:      state_next = ST_B_CHK;
      ST_B_CHK:     state_next = ST_B_ACC;
      ST_B_ACC:     state_next = q_last ? ST_A_NEXT : ST_B_RD;
      ST_ELEM_DONE: state_next = elem_last ? ST_EMIT_RD : ST_ELEM;
      ST_EMIT_RD:   state_next = ST_EMIT_LOAD;
      ST_EMIT_LOAD: state_next = ST_EMIT_WAIT;
      ST_EMIT_WAIT: begin
        if (m_tready) begin
          state_next = m_tlast ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == ST_IDLE);
    a_wr     = 1'b0;
    b_wr     = 1'b0;
    buf_we   = 1'b0;
    case (state)
      ST_IDLE: begin
        a_wr = s_tvalid && kind_t'(s_tuser) == KIND_LOAD_A && a_count != CNT_W'(MAX_TERMS);
        b_wr = s_tvalid && kind_t'(s_tuser) == KIND_LOAD_B && b_count != CNT_W'(MAX_TERMS);
      end
      ST_ELEM_DONE: buf_we = (acc != '0) && (n != 5'(OUT_CAP));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      a_count  <= '0;
      b_count  <= '0;
      load_ovf <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            case (kind_t'(s_tuser))
              KIND_LOAD_A: begin
                if (a_wr) a_count <= CNT_W'(a_count + 1'b1);
                else      load_ovf <= 1'b1;
              end
              KIND_LOAD_B: begin
                if (b_wr) b_count <= CNT_W'(b_count + 1'b1);
                else      load_ovf <= 1'b1;
              end
              KIND_COMPUTE: begin
                rows_lim <= in_rows_lim;
                cols_lim <= in_cols_lim;
                i        <= '0;
                j        <= '0;
                n        <= '0;
                k        <= '0;
                dropped  <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        ST_ELEM: begin
          acc <= '0;
          p   <= '0;
        end
        ST_A_CHK: begin
          q       <= '0;
          a_col_l <= a_rd.col;
          a_val_l <= a_rd.val;
        end
        ST_A_NEXT: p <= CNT_W'(p + 1'b1);
        ST_B_CHK:  prod <= b_match ? a_val_l * b_rd.val : 32'sd0;
        ST_B_ACC: begin
          acc <= acc + ACC_W'(prod);
          q   <= CNT_W'(q + 1'b1);
        end
        ST_ELEM_DONE: begin
          if (acc != '0) begin
            if (n != 5'(OUT_CAP)) n <= 5'(n + 1'b1);
            else                  dropped <= 1'b1;
          end
          if (col_last) begin
            j <= '0;
            i <= 5'(i + 1'b1);
          end else begin
            j <= 5'(j + 1'b1);
          end
        end
        ST_EMIT_LOAD: begin
          m_tvalid <= 1'b1;
          m_tlast  <= emit_last;
          m_tuser  <= {load_ovf | dropped, n != '0};
          if (n == '0) begin
            m_tdata <= '0;
          end else begin
            m_tdata <= {4'd0, buf_rd.val, buf_rd.col, buf_rd.row};
          end
        end
        ST_EMIT_WAIT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            k        <= 5'(k + 1'b1);
            if (m_tlast) begin
              a_count  <= '0;
              b_count  <= '0;
              load_ovf <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/stm_term_store.sv
// ----------------------------------------------------------------------------
// stm_term_store
// Term memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module stm_term_store #(
  parameter int DEPTH = stm_pkg::DEF_MAX_TERMS,
  parameter int IDX_W = 4
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  stm_pkg::term_t    wr_data,
  input  logic [IDX_W-1:0]  rd_addr,
  output stm_pkg::term_t    rd_data
);
  import stm_pkg::*;

  term_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hdl/stm_result_buf.sv
// ----------------------------------------------------------------------------
// stm_result_buf
// Holds the nonzero product elements until the whole product has been scanned.
// ----------------------------------------------------------------------------
module stm_result_buf (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [stm_pkg::OUT_IDX_W-1:0] wr_addr,
  input  stm_pkg::elem_t             wr_data,
  input  logic [stm_pkg::OUT_IDX_W-1:0] rd_addr,
  output stm_pkg::elem_t             rd_data
);
  import stm_pkg::*;

  elem_t mem [OUT_CAP];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> tb/sv/tb_sparse_triplet_multiply_top.sv
// ----------------------------------------------------------------------------
// tb_sparse_triplet_multiply_top
// Self-checking bench for the sparse triplet multiplier: loads random
// coordinate terms of A and B, issues compute beats, predicts every product
// beat and checks them in order under random stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sparse_triplet_multiply_top;
  import stm_pkg::*;

  localparam int TERMS = 16;
  localparam int DIMS  = 16;
  localparam longint VMAX = 64'sd34359738367;
  localparam longint VMIN = -64'sd34359738368;
  localparam int LIMIT = 3000000;

  typedef struct {
    logic [3:0]  row;
    logic [3:0]  col;
    logic [35:0] value;
    logic        has_term;
    logic        last;
    logic        overflow;
  } prod_beat_t;

  class product_scoreboard;
    term_t a_terms[$];
    term_t b_terms[$];
    bit dropped_load;
    prod_beat_t pending[$];
    int errors;

    function void reset_state();
      a_terms.delete();
      b_terms.delete();
      dropped_load = 0;
    endfunction

    function longint element(int i, int j);
      longint acc;
      acc = 0;
      foreach (a_terms[p])
        if (a_terms[p].row == i)
          foreach (b_terms[q])
            if (b_terms[q].col == j && b_terms[q].row == a_terms[p].col)
              acc += longint'(a_terms[p].val) * longint'(b_terms[q].val);
      return acc;
    endfunction

    function void note_input(kind_t kind, term_t t, int rows, int cols);
      prod_beat_t b;
      longint s;
      bit lost;
      int first;
      case (kind)
        KIND_LOAD_A: begin
          if (a_terms.size() < TERMS) a_terms.push_back(t);
          else dropped_load = 1;
        end
        KIND_LOAD_B: begin
          if (b_terms.size() < TERMS) b_terms.push_back(t);
          else dropped_load = 1;
        end
        KIND_COMPUTE: begin
          lost = 0;
          first = pending.size();
          if (rows > DIMS) rows = DIMS;
          if (cols > DIMS) cols = DIMS;
          for (int i = 0; i < rows; i++)
            for (int j = 0; j < cols; j++) begin
              s = element(i, j);
              if (s == 0) continue;
              if (pending.size() - first >= OUT_CAP) begin
                lost = 1;
                continue;
              end
              if (s > VMAX) s = VMAX;
              if (s < VMIN) s = VMIN;
              b.row = 4'(i); b.col = 4'(j); b.value = s[35:0];
              b.has_term = 1; b.last = 0; b.overflow = 0;
              pending.push_back(b);
            end
          if (pending.size() == first) begin
            b.row = 0; b.col = 0; b.value = 0; b.has_term = 0;
            pending.push_back(b);
          end
          for (int k = first; k < pending.size(); k++)
            pending[k].overflow = dropped_load | lost;
          pending[pending.size()-1].last = 1;
          reset_state();
        end
        default: ;
      endcase
    endfunction

    task check_result(prod_beat_t got);
      prod_beat_t w;
      if (pending.size() == 0) begin
        report_mismatch("result beat with nothing expected");
        return;
      end
      w = pending.pop_front();
      if (got.row !== w.row) report_mismatch($sformatf("row %0d want %0d", got.row, w.row));
      if (got.col !== w.col) report_mismatch($sformatf("col %0d want %0d", got.col, w.col));
      if (got.value !== w.value)
        report_mismatch($sformatf("value %h want %h", got.value, w.value));
      if (got.has_term !== w.has_term) report_mismatch("has_term differs");
      if (got.last !== w.last) report_mismatch("last differs");
      if (got.overflow !== w.overflow) report_mismatch("overflow differs");
    endtask

    task report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask
  endclass

  logic clk, rst;
  logic s_tvalid, s_tready;
  logic [39:0] s_tdata;
  logic [1:0] s_tuser;
  logic m_tvalid, m_tready;
  logic [47:0] m_tdata;
  logic [1:0] m_tuser;
  logic m_tlast;

  product_scoreboard board;
  longint cycles;
  bit stall_free;
  int items_sent;

  sparse_triplet_multiply_top uut (.*);

  always begin
    clk = 0; #5;
    clk = 1; #5;
  end

  function automatic int gap_len();
    if (stall_free) return 0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 0;
      5, 6, 7: return $urandom_range(1, 2);
      8: return $urandom_range(3, 6);
      default: return $urandom_range(10, 30);
    endcase
  endfunction

  // Receiver: random back-pressure, each beat checked at the edge it lands.
  always @(posedge clk) begin
    prod_beat_t got;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("sparse_triplet_multiply_top test failed");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) begin
      got.row = m_tdata[3:0];
      got.col = m_tdata[7:4];
      got.value = m_tdata[43:8];
      got.has_term = m_tuser[0];
      got.overflow = m_tuser[1];
      got.last = m_tlast;
      board.check_result(got);
    end
    m_tready <= stall_free ? 1'b1 : ($urandom_range(0, 3) != 0);
  end

  // The valid line drops only for a gap, so back-to-back beats never see two
  // updates of it in one time step.
  task automatic send_beat(kind_t kind, logic [3:0] r, logic [3:0] c, logic [15:0] v,
                           logic [4:0] rows, logic [4:0] cols);
    term_t t;
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= kind;
    s_tdata <= {6'd0, cols, rows, v, c, r};
    do @(posedge clk); while (!s_tready);
    t.row = r; t.col = c; t.val = v;
    board.note_input(kind, t, rows, cols);
    items_sent++;
  endtask

  task automatic load_term(kind_t kind, int r, int c, int v);
    send_beat(kind, 4'(r), 4'(c), 16'(v), 5'($urandom), 5'($urandom));
  endtask

  task automatic compute(int rows, int cols);
    send_beat(KIND_COMPUTE, 4'($urandom), 4'($urandom), 16'($urandom), 5'(rows), 5'(cols));
  endtask

  // One product with random terms confined to a random square corner of the matrices.
  task automatic random_product();
    int na, nb, dim, rows, cols;
    na = $urandom_range(0, 3) == 0 ? $urandom_range(14, 18) : $urandom_range(0, 6);
    nb = $urandom_range(0, 3) == 0 ? $urandom_range(14, 18) : $urandom_range(0, 6);
    dim = $urandom_range(1, 16);
    for (int k = 0; k < na + nb; k++) begin
      if ($urandom_range(0, 15) == 0)
        send_beat(KIND_UNUSED, 4'($urandom), 4'($urandom), 16'($urandom), 5'($urandom),
                  5'($urandom));
      load_term(k < na ? KIND_LOAD_A : KIND_LOAD_B, $urandom_range(0, dim - 1),
                $urandom_range(0, dim - 1),
                $urandom_range(0, 7) == 0 ? $urandom : $signed($urandom_range(0, 20)) - 10);
    end
    rows = $urandom_range(0, 9) == 0 ? $urandom_range(0, 31) : dim;
    cols = $urandom_range(0, 9) == 0 ? $urandom_range(0, 31) : dim;
    compute(rows, cols);
  endtask

  initial begin
    board = new();
    board.reset_state();
    cycles = 0;
    items_sent = 0;
    stall_free = 0;
    rst = 1;
    s_tvalid = 0; s_tdata = '0; s_tuser = KIND_LOAD_A; m_tready = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Empty product and a zero dimension.
    compute(16, 16);
    compute(0, 5);
    // Extreme values and oversized dimensions: saturation needs many duplicate terms at full magnitude.
    for (int k = 0; k < 2; k++) load_term(KIND_LOAD_A, 15, 0, -32768);
    load_term(KIND_LOAD_B, 0, 15, -32768);
    load_term(KIND_LOAD_A, 0, 15, 32767);
    load_term(KIND_LOAD_B, 15, 0, 16'hffff);
    send_beat(KIND_UNUSED, 4'hf, 4'hf, 16'hffff, 5'h1f, 5'h1f);
    compute(31, 31);
    // Duplicate terms cancelling to zero leave an empty product.
    load_term(KIND_LOAD_A, 3, 4, 5);
    load_term(KIND_LOAD_A, 3, 4, -5);
    load_term(KIND_LOAD_B, 4, 7, 9);
    compute(16, 16);
    // A full store drops terms; too many nonzeros also sets overflow.
    for (int k = 0; k < 17; k++) load_term(KIND_LOAD_A, k % 16, 0, 1);
    for (int k = 0; k < 17; k++) load_term(KIND_LOAD_B, 0, k % 16, 1);
    compute(16, 16);
    // Saturation at both ends: 16x16 products of full-scale values.
    for (int k = 0; k < 16; k++) load_term(KIND_LOAD_A, 0, 0, -32768);
    for (int k = 0; k < 16; k++) load_term(KIND_LOAD_B, 0, k / 8, k < 8 ? -32768 : 32767);
    compute(1, 2);

    while (items_sent < 220) begin
      stall_free = ($urandom_range(0, 7) == 0);
      random_product();
    end
    s_tvalid <= 0;
    stall_free = 0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (board.errors == 0)
      $display("sparse_triplet_multiply_top test passed");
    else
      $display("sparse_triplet_multiply_top test failed");
    $finish;
  end

endmodule
